// ----- hw/rtl/btpc_pkg.sv -----
// btpc_pkg: shared widths, config register indexes, scaling shifts and the
// truncating signed shift-divide used by the compensation pipeline.
// No dependencies.
`default_nettype none

package btpc_pkg;

    localparam int RAW_W   = 24;
    localparam int TEMP_W  = 19;
    localparam int PRESS_W = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAL_TEMP    = 3'd0,
        CFG_CAL_P1_P2   = 3'd1,
        CFG_CAL_P3_P4   = 3'd2,
        CFG_CAL_P5_P6   = 3'd3,
        CFG_CAL_P7_P8   = 3'd4,
        CFG_CAL_P9      = 3'd5,
        CFG_CAL_P10_P11 = 3'd6
    } cfg_index_t;

    // scaling shifts (powers of two of the polynomial)
    localparam int LIN_T2_SH  = 18;
    localparam int LIN_SH     = 32;
    localparam int TEMP_SH    = 14;
    localparam int TSQ_SH     = 6;
    localparam int TSQ_SPLIT  = 24;
    localparam int TCUBE_SH   = 8;
    localparam int CUBE_SH    = 5;
    localparam int OFF_P5_SH  = 47;
    localparam int OFF_P7_SH  = 4;
    localparam int OFF_P6_SH  = 22;
    localparam int SENS_P1_SH = 46;
    localparam int SENS_P3_SH = 2;
    localparam int SENS_P2_SH = 21;
    localparam int SENS_SH    = 24;
    localparam int B_P9_SH    = 16;
    localparam int C1_SH      = 13;
    localparam int C2_SH      = 9;
    localparam int E1_SH      = 16;
    localparam int E2_SH      = 7;
    localparam int OFF_SH     = 2;
    localparam int PRESS_SH   = 40;

    localparam logic signed [16:0] COEF_BIAS = 17'sd16384;
    localparam logic [63:0]        SCALE_25  = 64'd25;

    // signed divide by 2^k, truncating toward zero
    function automatic logic signed [63:0] sdiv_pow2(input logic signed [63:0] x,
                                                     input int unsigned k);
        logic signed [63:0] bias;
        bias = x[63] ? $signed((64'd1 << k) - 64'd1) : 64'sd0;
        return (x + bias) >>> k;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/btpc_sample_if.sv -----
// btpc_sample_if: request channel carrying one raw temperature/pressure pair.
// Depends on btpc_pkg.
`default_nettype none

interface btpc_sample_if;
    logic                          valid;
    logic                          ready;
    logic [btpc_pkg::RAW_W-1:0]    raw_temperature;
    logic [btpc_pkg::RAW_W-1:0]    raw_pressure;

    modport source (output valid, output raw_temperature, output raw_pressure,
                    input ready);
    modport sink   (input valid, input raw_temperature, input raw_pressure,
                    output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/btpc_result_if.sv -----
// btpc_result_if: request channel carrying one compensated temperature/pressure.
// Depends on btpc_pkg.
`default_nettype none

interface btpc_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [btpc_pkg::TEMP_W-1:0]   temperature_centi;
    logic [btpc_pkg::PRESS_W-1:0]         pressure_centi;

    modport source (output valid, output temperature_centi, output pressure_centi,
                    input ready);
    modport sink   (input valid, input temperature_centi, input pressure_centi,
                    output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/btpc_cfg_if.sv -----
// btpc_cfg_if: calibration register write channel (index + data).
// Depends on btpc_pkg.
`default_nettype none

interface btpc_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [btpc_pkg::CFG_IDX_W-1:0]      index;
    logic [btpc_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/baro_temp_pressure_compensation.sv -----
// baro_temp_pressure_compensation: 14-stage integer compensation pipeline.
// Depends on btpc_pkg, btpc_sample_if, btpc_result_if, btpc_cfg_if.
//
// channel   dir   payload                              notes
// sample    in    raw_temperature[23:0], raw_pressure  one request per sample pair
// result    out   temperature_centi[18:0] s, pressure  one request per sample pair
// cfg       in    index[2:0], data[39:0]               ready tied high
//
// One sample pair per cycle unless result stalls; results leave the last stage.
// Latency is set by the chain of dependent multiplies (tlin, tlin^3, offset/sens).
// Each stage holds while the one after it is full and stalled; bubbles close up.
// Reset clears the stage valid bits and the calibration registers.
`default_nettype none

module baro_temp_pressure_compensation (
    input  wire              clk,
    input  wire              rst_n,
    btpc_sample_if.sink      sample,
    btpc_result_if.source    result,
    btpc_cfg_if.sink         cfg
);

    localparam int NSTG = 14;

    // calibration registers
    logic [39:0] cal_temp_reg;
    logic [31:0] cal_p1_p2_reg;
    logic [15:0] cal_p3_p4_reg;
    logic [31:0] cal_p5_p6_reg;
    logic [15:0] cal_p7_p8_reg;
    logic [15:0] cal_p9_reg;
    logic [15:0] cal_p10_p11_reg;

    logic [15:0]        t1, t2, p5, p6;
    logic signed [7:0]  t3, p3, p4, p7, p8, p10, p11;
    logic signed [15:0] p9;
    logic signed [16:0] p1m, p2m;

    assign t1  = cal_temp_reg[15:0];
    assign t2  = cal_temp_reg[31:16];
    assign t3  = $signed(cal_temp_reg[39:32]);
    assign p1m = $signed({cal_p1_p2_reg[15], cal_p1_p2_reg[15:0]}) - btpc_pkg::COEF_BIAS;
    assign p2m = $signed({cal_p1_p2_reg[31], cal_p1_p2_reg[31:16]}) - btpc_pkg::COEF_BIAS;
    assign p3  = $signed(cal_p3_p4_reg[7:0]);
    assign p4  = $signed(cal_p3_p4_reg[15:8]);
    assign p5  = cal_p5_p6_reg[15:0];
    assign p6  = cal_p5_p6_reg[31:16];
    assign p7  = $signed(cal_p7_p8_reg[7:0]);
    assign p8  = $signed(cal_p7_p8_reg[15:8]);
    assign p9  = $signed(cal_p9_reg);
    assign p10 = $signed(cal_p10_p11_reg[7:0]);
    assign p11 = $signed(cal_p10_p11_reg[15:8]);

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_temp_reg    <= '0;
            cal_p1_p2_reg   <= '0;
            cal_p3_p4_reg   <= '0;
            cal_p5_p6_reg   <= '0;
            cal_p7_p8_reg   <= '0;
            cal_p9_reg      <= '0;
            cal_p10_p11_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (btpc_pkg::cfg_index_t'(cfg.index))
                btpc_pkg::CFG_CAL_TEMP:    cal_temp_reg    <= cfg.data;
                btpc_pkg::CFG_CAL_P1_P2:   cal_p1_p2_reg   <= cfg.data[31:0];
                btpc_pkg::CFG_CAL_P3_P4:   cal_p3_p4_reg   <= cfg.data[15:0];
                btpc_pkg::CFG_CAL_P5_P6:   cal_p5_p6_reg   <= cfg.data[31:0];
                btpc_pkg::CFG_CAL_P7_P8:   cal_p7_p8_reg   <= cfg.data[15:0];
                btpc_pkg::CFG_CAL_P9:      cal_p9_reg      <= cfg.data[15:0];
                btpc_pkg::CFG_CAL_P10_P11: cal_p10_p11_reg <= cfg.data[15:0];
                default:                   ;
            endcase
        end
    end

    // stage control
    logic [NSTG:1] v_reg;
    logic [NSTG:1] en;

    always_comb
    begin
        en[NSTG] = !v_reg[NSTG] || result.ready;
        for (int k = NSTG - 1; k >= 1; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign sample.ready = en[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                v_reg[1] <= sample.valid;
            end
            for (int k = 2; k <= NSTG; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // payload registers
    logic [23:0]        rp_reg [1:11];
    logic signed [24:0] s1_d_reg;
    logic [47:0]        s1_psq_reg;
    logic signed [40:0] s2_t2d_reg;
    logic [47:0]        s2_dsq_reg;
    logic signed [56:0] s2_p11sq_reg;
    logic signed [59:0] s3_lin_reg;
    logic signed [39:0] s3_e1_reg;
    logic signed [27:0] s4_tlin_reg;
    logic [63:0]        s4_e2_reg;
    logic signed [27:0] s5_tlin_reg;
    logic [54:0]        s5_tsq_reg;
    logic signed [32:0] s5_t25_reg;
    logic signed [36:0] s5_b_reg;
    logic signed [56:0] e3_reg [5:12];
    logic signed [44:0] m6_reg [5:9];
    logic signed [44:0] m2_reg [5:9];
    logic signed [18:0] temp_reg [6:14];
    logic signed [53:0] s6_ph_reg;
    logic signed [52:0] s6_pl_reg;
    logic signed [62:0] m7_reg [6:9];
    logic signed [62:0] m3_reg [6:9];
    logic signed [61:0] s6_c1_reg;
    logic [63:0]        s7_tc_reg;
    logic signed [47:0] s7_c2_reg;
    logic signed [55:0] s8_tcube_reg;
    logic [63:0]        s8_c3_reg;
    logic [63:0]        s9_q8_reg;
    logic [63:0]        s9_q4_reg;
    logic signed [54:0] cc_reg [9:12];
    logic [63:0]        s10_off_reg;
    logic [63:0]        s10_sens_reg;
    logic signed [39:0] s11_s24_reg;
    logic signed [61:0] o4_reg [11:12];
    logic [63:0]        s12_a_reg;
    logic [63:0]        s13_total_reg;
    logic [23:0]        s14_press_reg;

    // next values
    logic signed [24:0] s1_d_next;
    logic [47:0]        s1_psq_next;
    logic signed [40:0] s2_t2d_next;
    logic signed [49:0] dsq_full;
    logic signed [56:0] s2_p11sq_next;
    logic signed [59:0] t2d_x;
    logic signed [56:0] dsq_t3;
    logic signed [59:0] s3_lin_next;
    logic signed [63:0] div_e1, div_tlin, div_e3, div_temp, div_c2, div_tcube;
    logic signed [63:0] div_c, div_q8, div_q4, div_s24, div_o4;
    logic signed [64:0] e2_full;
    logic signed [55:0] tsq_full;
    logic signed [32:0] s5_t25_next;
    logic signed [44:0] s5_m6_next, s5_m2_next;
    logic signed [36:0] s5_b_next;
    logic [48:0]        tsq64;
    logic signed [53:0] s6_ph_next;
    logic signed [52:0] s6_pl_next;
    logic signed [62:0] s6_m7_next, s6_m3_next;
    logic signed [61:0] s6_c1_next;
    logic signed [63:0] pl_x;
    logic [63:0]        s7_tc_next;
    logic signed [72:0] c3_full;
    logic signed [63:0] s9_q8_next, s9_q4_next;
    logic signed [63:0] m7_x, m3_x, m6_x, m2_x, p1_x;
    logic [63:0]        s10_off_next, s10_sens_next;
    logic signed [64:0] a_full;
    logic signed [63:0] s13_total_next;
    logic [63:0]        pmul;

    always_comb
    begin
        // stage 1
        s1_d_next   = $signed({1'b0, sample.raw_temperature}) - $signed({1'b0, t1, 8'h00});
        s1_psq_next = sample.raw_pressure * sample.raw_pressure;
        // stage 2
        s2_t2d_next   = $signed({1'b0, t2}) * s1_d_reg;
        dsq_full      = s1_d_reg * s1_d_reg;
        s2_p11sq_next = p11 * $signed({1'b0, s1_psq_reg});
        // stage 3
        t2d_x       = s2_t2d_reg;
        dsq_t3      = t3 * $signed({1'b0, s2_dsq_reg});
        s3_lin_next = (t2d_x <<< btpc_pkg::LIN_T2_SH) + dsq_t3;
        div_e1      = btpc_pkg::sdiv_pow2(s2_p11sq_reg, btpc_pkg::E1_SH);
        // stage 4
        div_tlin = btpc_pkg::sdiv_pow2(s3_lin_reg, btpc_pkg::LIN_SH);
        e2_full  = s3_e1_reg * $signed({1'b0, rp_reg[3]});
        // stage 5
        tsq_full    = s4_tlin_reg * s4_tlin_reg;
        s5_t25_next = s4_tlin_reg * 33'sd25;
        s5_m6_next  = $signed({1'b0, p6}) * s4_tlin_reg;
        s5_m2_next  = p2m * s4_tlin_reg;
        s5_b_next   = p10 * s4_tlin_reg + $signed({p9, 16'h0000});
        div_e3      = btpc_pkg::sdiv_pow2($signed(s4_e2_reg), btpc_pkg::E2_SH);
        // stage 6
        div_temp   = btpc_pkg::sdiv_pow2(s5_t25_reg, btpc_pkg::TEMP_SH);
        tsq64      = s5_tsq_reg[54:btpc_pkg::TSQ_SH];
        s6_ph_next = $signed({1'b0, tsq64[48:btpc_pkg::TSQ_SPLIT]}) * s5_tlin_reg;
        s6_pl_next = $signed({1'b0, tsq64[btpc_pkg::TSQ_SPLIT-1:0]}) * s5_tlin_reg;
        s6_m7_next = p7 * $signed({1'b0, s5_tsq_reg});
        s6_m3_next = p3 * $signed({1'b0, s5_tsq_reg});
        s6_c1_next = s5_b_reg * $signed({1'b0, rp_reg[5]});
        // stage 7
        pl_x       = s6_pl_reg;
        s7_tc_next = {s6_ph_reg[39:0], 24'h000000} + pl_x;
        div_c2     = btpc_pkg::sdiv_pow2(s6_c1_reg, btpc_pkg::C1_SH);
        // stage 8
        div_tcube = btpc_pkg::sdiv_pow2($signed(s7_tc_reg), btpc_pkg::TCUBE_SH);
        c3_full   = s7_c2_reg * $signed({1'b0, rp_reg[7]});
        // stage 9
        s9_q8_next = p8 * s8_tcube_reg;
        s9_q4_next = p4 * s8_tcube_reg;
        div_c      = btpc_pkg::sdiv_pow2($signed(s8_c3_reg), btpc_pkg::C2_SH);
        // stage 10
        div_q8 = btpc_pkg::sdiv_pow2($signed(s9_q8_reg), btpc_pkg::CUBE_SH);
        div_q4 = btpc_pkg::sdiv_pow2($signed(s9_q4_reg), btpc_pkg::CUBE_SH);
        m7_x   = m7_reg[9];
        m3_x   = m3_reg[9];
        m6_x   = m6_reg[9];
        m2_x   = m2_reg[9];
        p1_x   = p1m;
        s10_off_next  = (64'(p5) << btpc_pkg::OFF_P5_SH) + $unsigned(div_q8)
                      + $unsigned(m7_x <<< btpc_pkg::OFF_P7_SH)
                      + $unsigned(m6_x <<< btpc_pkg::OFF_P6_SH);
        s10_sens_next = $unsigned(p1_x <<< btpc_pkg::SENS_P1_SH) + $unsigned(div_q4)
                      + $unsigned(m3_x <<< btpc_pkg::SENS_P3_SH)
                      + $unsigned(m2_x <<< btpc_pkg::SENS_P2_SH);
        // stage 11
        div_s24 = btpc_pkg::sdiv_pow2($signed(s10_sens_reg), btpc_pkg::SENS_SH);
        div_o4  = btpc_pkg::sdiv_pow2($signed(s10_off_reg), btpc_pkg::OFF_SH);
        // stage 12
        a_full = s11_s24_reg * $signed({1'b0, rp_reg[11]});
        // stage 13
        s13_total_next = o4_reg[12] + $signed(s12_a_reg) + cc_reg[12] + e3_reg[12];
        // stage 14
        pmul = s13_total_reg * btpc_pkg::SCALE_25;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            rp_reg[1]  <= sample.raw_pressure;
            s1_d_reg   <= s1_d_next;
            s1_psq_reg <= s1_psq_next;
        end
        for (int k = 2; k <= 11; k++)
        begin
            if (en[k])
            begin
                rp_reg[k] <= rp_reg[k-1];
            end
        end
        if (en[2])
        begin
            s2_t2d_reg   <= s2_t2d_next;
            s2_dsq_reg   <= dsq_full[47:0];
            s2_p11sq_reg <= s2_p11sq_next;
        end
        if (en[3])
        begin
            s3_lin_reg <= s3_lin_next;
            s3_e1_reg  <= div_e1[39:0];
        end
        if (en[4])
        begin
            s4_tlin_reg <= div_tlin[27:0];
            s4_e2_reg   <= e2_full[63:0];
        end
        if (en[5])
        begin
            s5_tlin_reg <= s4_tlin_reg;
            s5_tsq_reg  <= tsq_full[54:0];
            s5_t25_reg  <= s5_t25_next;
            s5_b_reg    <= s5_b_next;
            m6_reg[5]   <= s5_m6_next;
            m2_reg[5]   <= s5_m2_next;
            e3_reg[5]   <= div_e3[56:0];
        end
        if (en[6])
        begin
            temp_reg[6] <= div_temp[18:0];
            s6_ph_reg   <= s6_ph_next;
            s6_pl_reg   <= s6_pl_next;
            m7_reg[6]   <= s6_m7_next;
            m3_reg[6]   <= s6_m3_next;
            s6_c1_reg   <= s6_c1_next;
        end
        for (int k = 6; k <= 9; k++)
        begin
            if (en[k])
            begin
                m6_reg[k] <= m6_reg[k-1];
                m2_reg[k] <= m2_reg[k-1];
            end
        end
        for (int k = 7; k <= 9; k++)
        begin
            if (en[k])
            begin
                m7_reg[k] <= m7_reg[k-1];
                m3_reg[k] <= m3_reg[k-1];
            end
        end
        for (int k = 6; k <= 12; k++)
        begin
            if (en[k])
            begin
                e3_reg[k] <= e3_reg[k-1];
            end
        end
        for (int k = 7; k <= NSTG; k++)
        begin
            if (en[k])
            begin
                temp_reg[k] <= temp_reg[k-1];
            end
        end
        if (en[7])
        begin
            s7_tc_reg <= s7_tc_next;
            s7_c2_reg <= div_c2[47:0];
        end
        if (en[8])
        begin
            s8_tcube_reg <= div_tcube[55:0];
            s8_c3_reg    <= c3_full[63:0];
        end
        if (en[9])
        begin
            s9_q8_reg <= s9_q8_next;
            s9_q4_reg <= s9_q4_next;
            cc_reg[9] <= div_c[54:0];
        end
        for (int k = 10; k <= 12; k++)
        begin
            if (en[k])
            begin
                cc_reg[k] <= cc_reg[k-1];
            end
        end
        if (en[10])
        begin
            s10_off_reg  <= s10_off_next;
            s10_sens_reg <= s10_sens_next;
        end
        if (en[11])
        begin
            s11_s24_reg <= div_s24[39:0];
            o4_reg[11]  <= div_o4[61:0];
        end
        if (en[12])
        begin
            o4_reg[12] <= o4_reg[11];
            s12_a_reg  <= a_full[63:0];
        end
        if (en[13])
        begin
            s13_total_reg <= s13_total_next;
        end
        if (en[14])
        begin
            s14_press_reg <= pmul[63:btpc_pkg::PRESS_SH];
        end
    end

    assign result.valid             = v_reg[NSTG];
    assign result.temperature_centi = temp_reg[NSTG];
    assign result.pressure_centi    = s14_press_reg;

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// tb_top: self-checking bench for baro_temp_pressure_compensation, with a
// bursty sample driver, a stalling result sink and a 64-bit integer predictor.
// Depends on btpc_pkg, btpc_sample_if, btpc_result_if, btpc_cfg_if and the block.
`timescale 1ns / 100ps

module tb_top;
    import btpc_pkg::*;

    localparam int  CLK_PERIOD   = 20;
    localparam int  RESET_CYCLES = 12;
    localparam int  TAIL_CYCLES  = 20;
    localparam int  CYCLE_LIMIT  = 500000;
    localparam int  RANDOM_PAIRS = 170;
    localparam int  MAX_REPORTS  = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

    localparam longint LIN_DIV  = 64'sd4294967296;
    localparam longint OFF_P5_K = 64'sd140737488355328;
    localparam longint SENS_P1_K = 64'sd70368744177664;

    typedef struct packed {
        logic [RAW_W-1:0] raw_t;
        logic [RAW_W-1:0] raw_p;
    } sample_pair_t;

    typedef struct packed {
        logic [RAW_W-1:0]          raw_t;
        logic [RAW_W-1:0]          raw_p;
        logic signed [TEMP_W-1:0]  temperature_centi;
        logic [PRESS_W-1:0]        pressure_centi;
    } reading_t;

    logic clk;
    logic rst_n;

    btpc_sample_if sample_ch();
    btpc_result_if result_ch();
    btpc_cfg_if    cfg_ch();

    baro_temp_pressure_compensation uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // calibration as the block should hold it
    logic [39:0] cal_temp;
    logic [31:0] cal_p1_p2;
    logic [15:0] cal_p3_p4;
    logic [31:0] cal_p5_p6;
    logic [15:0] cal_p7_p8;
    logic [15:0] cal_p9;
    logic [15:0] cal_p10_p11;

    sample_pair_t sample_backlog[$];
    reading_t     expected_readings[$];
    int           pairs_queued;
    int           readings_seen;
    int           mismatch_count;
    int           cycle_count;

    sample_pair_t next_pair;
    int           burst_left;
    int           gap_left;
    int           gap_pick;
    logic [15:0]  stall_pat;
    int           pat_age;

    function automatic reading_t compensate(input logic [RAW_W-1:0] raw_t,
                                            input logic [RAW_W-1:0] raw_p);
        longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
        longint rt, rp, d, tlin, temp, tsq, tcube, offset, sens;
        longint a, b, c, e, total;
        logic [63:0] scaled;
        reading_t r;
        t1  = longint'(cal_temp[15:0]);
        t2  = longint'(cal_temp[31:16]);
        t3  = longint'($signed(cal_temp[39:32]));
        p1  = longint'($signed(cal_p1_p2[15:0]));
        p2  = longint'($signed(cal_p1_p2[31:16]));
        p3  = longint'($signed(cal_p3_p4[7:0]));
        p4  = longint'($signed(cal_p3_p4[15:8]));
        p5  = longint'(cal_p5_p6[15:0]);
        p6  = longint'(cal_p5_p6[31:16]);
        p7  = longint'($signed(cal_p7_p8[7:0]));
        p8  = longint'($signed(cal_p7_p8[15:8]));
        p9  = longint'($signed(cal_p9));
        p10 = longint'($signed(cal_p10_p11[7:0]));
        p11 = longint'($signed(cal_p10_p11[15:8]));
        rt  = longint'(raw_t);
        rp  = longint'(raw_p);

        d     = rt - 256 * t1;
        tlin  = ((t2 * d) * 262144 + (d * d) * t3) / LIN_DIV;
        temp  = (tlin * 25) / 16384;

        tsq    = tlin * tlin;
        tcube  = ((tsq / 64) * tlin) / 256;
        offset = p5 * OFF_P5_K + (p8 * tcube) / 32 + p7 * tsq * 16
               + p6 * tlin * 4194304;
        sens   = (p1 - 16384) * SENS_P1_K + (p4 * tcube) / 32 + p3 * tsq * 4
               + (p2 - 16384) * tlin * 2097152;

        a      = (sens / 16777216) * rp;
        b      = p10 * tlin + 65536 * p9;
        c      = (((b * rp) / 8192) * rp) / 512;
        e      = (((p11 * (rp * rp)) / 65536) * rp) / 128;
        total  = offset / 4 + a + c + e;
        scaled = total * 25;

        r.raw_t             = raw_t;
        r.raw_p             = raw_p;
        r.temperature_centi = temp[TEMP_W-1:0];
        r.pressure_centi    = scaled[63:40];
        return r;
    endfunction

    task automatic write_cal(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_CAL_TEMP:    cal_temp    = val[39:0];
            CFG_CAL_P1_P2:   cal_p1_p2   = val[31:0];
            CFG_CAL_P3_P4:   cal_p3_p4   = val[15:0];
            CFG_CAL_P5_P6:   cal_p5_p6   = val[31:0];
            CFG_CAL_P7_P8:   cal_p7_p8   = val[15:0];
            CFG_CAL_P9:      cal_p9      = val[15:0];
            CFG_CAL_P10_P11: cal_p10_p11 = val[15:0];
            default: ;
        endcase
    endtask

    task automatic apply_calibration(input logic [39:0] t, input logic [31:0] p12,
                                     input logic [15:0] p34, input logic [31:0] p56,
                                     input logic [15:0] p78, input logic [15:0] p9,
                                     input logic [15:0] p1011);
        write_cal(CFG_CAL_TEMP, t);
        write_cal(CFG_CAL_P1_P2, {8'h00, p12});
        write_cal(CFG_CAL_P3_P4, {24'h0, p34});
        write_cal(CFG_CAL_P5_P6, {8'h00, p56});
        write_cal(CFG_CAL_P7_P8, {24'h0, p78});
        write_cal(CFG_CAL_P9, {24'h0, p9});
        write_cal(CFG_CAL_P10_P11, {24'h0, p1011});
        // unused index must leave every register alone
        write_cal(CFG_IDX_UNUSED, {8'($urandom), 32'($urandom)});
    endtask

    task automatic queue_pair(input logic [RAW_W-1:0] raw_t,
                              input logic [RAW_W-1:0] raw_p);
        sample_pair_t s;
        s.raw_t = raw_t;
        s.raw_p = raw_p;
        sample_backlog.push_back(s);
        pairs_queued++;
    endtask

    task automatic queue_corner_pairs();
        queue_pair(24'h000000, 24'h000000);
        queue_pair(24'hFFFFFF, 24'hFFFFFF);
        queue_pair(24'h000000, 24'hFFFFFF);
        queue_pair(24'hFFFFFF, 24'h000000);
    endtask

    task automatic queue_random_pairs(input int n);
        logic [RAW_W-1:0] corners[4];
        logic [RAW_W-1:0] rt, rp;
        int mode, v;
        corners = '{24'h000000, 24'hFFFFFF, 24'h800000, 24'h7FFFFF};
        repeat (n) begin
            mode = $urandom_range(0, 9);
            rt = 24'($urandom);
            rp = 24'($urandom);
            if (mode >= 5 && mode <= 7) begin
                // near the zero point of the temperature polynomial
                v  = int'(cal_temp[15:0]) * 256 + int'($urandom_range(0, 131071)) - 65536;
                rt = 24'(v);
            end else if (mode == 8) begin
                rt = corners[$urandom_range(0, 3)];
                rp = corners[$urandom_range(0, 3)];
            end else if (mode == 9) begin
                rt = 24'($urandom_range(7000000, 9000000));
                rp = 24'($urandom_range(5000000, 7500000));
            end
            queue_pair(rt, rp);
        end
    endtask

    task automatic drain();
        while (readings_seen < pairs_queued)
            @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[baro_temp_pressure_compensation] ERROR");
            $finish;
        end
    end

    // sample driver: bursts of requests separated by random gaps
    always @(posedge clk)
    begin
        if (!rst_n) begin
            sample_ch.valid           <= 1'b0;
            sample_ch.raw_temperature <= '0;
            sample_ch.raw_pressure    <= '0;
            burst_left                <= 1;
            gap_left                  <= 0;
        end else begin
            if (sample_ch.valid && sample_ch.ready)
                expected_readings.push_back(compensate(sample_ch.raw_temperature,
                                                       sample_ch.raw_pressure));
            if (sample_ch.valid && !sample_ch.ready) begin
                // hold the request
            end else if (gap_left != 0) begin
                sample_ch.valid <= 1'b0;
                gap_left        <= gap_left - 1;
            end else if (sample_backlog.size() != 0) begin
                next_pair = sample_backlog.pop_front();
                sample_ch.valid           <= 1'b1;
                sample_ch.raw_temperature <= next_pair.raw_t;
                sample_ch.raw_pressure    <= next_pair.raw_p;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 32);
                    gap_pick = $urandom_range(0, 9);
                    if (gap_pick < 3)
                        gap_left <= 0;
                    else if (gap_pick < 8)
                        gap_left <= $urandom_range(1, 4);
                    else
                        gap_left <= $urandom_range(5, 20);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                sample_ch.valid <= 1'b0;
            end
        end
    end

    // result sink: rotating stall pattern, re-picked each time pat_age wraps
    always @(posedge clk)
    begin
        if (!rst_n) begin
            result_ch.ready <= 1'b0;
            stall_pat       <= 16'hFFFF;
            pat_age         <= 0;
        end else begin
            result_ch.ready <= stall_pat[0];
            if (pat_age == 47) begin
                stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                         : (16'($urandom) | 16'h0001);
                pat_age   <= 0;
            end else begin
                stall_pat <= {stall_pat[0], stall_pat[15:1]};
                pat_age   <= pat_age + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && result_ch.valid && result_ch.ready) begin
            readings_seen <= readings_seen + 1;
            if (expected_readings.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: temp %0d press %0d",
                             result_ch.temperature_centi, result_ch.pressure_centi);
            end else begin
                want = expected_readings.pop_front();
                if (want.temperature_centi !== result_ch.temperature_centi ||
                    want.pressure_centi !== result_ch.pressure_centi) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch raw_t %06h raw_p %06h: temp exp %0d got %0d, press exp %0d got %0d",
                                 want.raw_t, want.raw_p,
                                 want.temperature_centi, result_ch.temperature_centi,
                                 want.pressure_centi, result_ch.pressure_centi);
                end
            end
        end
    end

    initial
    begin
        rst_n                     = 1'b0;
        sample_ch.valid           = 1'b0;
        sample_ch.raw_temperature = '0;
        sample_ch.raw_pressure    = '0;
        result_ch.ready           = 1'b0;
        cfg_ch.valid              = 1'b0;
        cfg_ch.index              = '0;
        cfg_ch.data               = '0;
        cal_temp       = '0;
        cal_p1_p2      = '0;
        cal_p3_p4      = '0;
        cal_p5_p6      = '0;
        cal_p7_p8      = '0;
        cal_p9         = '0;
        cal_p10_p11    = '0;
        pairs_queued   = 0;
        readings_seen  = 0;
        mismatch_count = 0;
        cycle_count    = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // reset calibration
        queue_corner_pairs();
        queue_random_pairs(RANDOM_PAIRS);
        drain();

        // typical sensor trim
        apply_calibration({8'hF9, 16'h4AAB, 16'h6B82}, {16'hF3E1, 16'hF8A2},
                          {8'h01, 8'h22}, {16'h7D15, 16'h6A7D}, {8'hF8, 8'h03},
                          16'h11F2, {8'hDA, 8'h0C});
        queue_pair(24'h6B8200, 24'h5B8D80);
        queue_pair(24'h000000, 24'h000000);
        queue_pair(24'hFFFFFF, 24'hFFFFFF);
        queue_pair(24'h6B8200, 24'h000000);
        queue_pair(24'h800000, 24'hFFFFFF);
        queue_pair(24'h7A1200, 24'h5F5E10);
        queue_pair(24'h6B8201, 24'h000001);
        queue_pair(24'h6B81FF, 24'h7FFFFF);
        queue_random_pairs(RANDOM_PAIRS);
        drain();

        apply_calibration(40'hFF_FFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,
                          16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_corner_pairs();
        queue_random_pairs(RANDOM_PAIRS);
        drain();

        // most negative signed coefficients
        apply_calibration({8'h80, 16'hFFFF, 16'hFFFF}, {16'h8000, 16'h8000},
                          16'h8080, 32'hFFFF_FFFF, 16'h8080, 16'h8000, 16'h8080);
        queue_corner_pairs();
        queue_random_pairs(RANDOM_PAIRS);
        drain();

        // most positive signed coefficients
        apply_calibration({8'h7F, 16'hFFFF, 16'h0000}, {16'h7FFF, 16'h7FFF},
                          16'h7F7F, 32'hFFFF_FFFF, 16'h7F7F, 16'h7FFF, 16'h7F7F);
        queue_corner_pairs();
        queue_random_pairs(RANDOM_PAIRS);
        drain();

        repeat (6) begin
            apply_calibration({8'($urandom), 32'($urandom)}, 32'($urandom),
                              16'($urandom), 32'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom));
            queue_random_pairs(RANDOM_PAIRS);
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_readings.size() == 0)
            $display("[baro_temp_pressure_compensation] OK");
        else
            $display("[baro_temp_pressure_compensation] ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/btpc_pkg.sv
hw/rtl/btpc_sample_if.sv
hw/rtl/btpc_result_if.sv
hw/rtl/btpc_cfg_if.sv
hw/rtl/baro_temp_pressure_compensation.sv
test/tb_top.sv
